// ===== hdl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int NUM_LANES = 8;
  localparam int DEF_MAX_MATRIX_SIDE = 64;
  localparam int DEF_MAX_BITMAP_SIDE = 32;
  localparam logic [6:0] MATRIX_SIDE_RESET = 7'd16;

  typedef enum logic {
    CFG_MATRIX_WIDTH  = 1'b0,
    CFG_MATRIX_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]        bitmap_byte;
    logic [1:0]        byte_column;
    logic [4:0]        bitmap_row;
    logic [5:0]        bitmap_width;
    logic [5:0]        bitmap_height;
    logic signed [7:0] origin_x;
    logic signed [7:0] origin_y;
    logic signed [7:0] rotation;
    logic [23:0]       pixel_color;
  } item_t;

  typedef struct packed {
    logic [11:0] led_index;
    logic [23:0] write_color;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              pix;
    logic [1:0]        bcol;
    logic [4:0]        row;
    logic [5:0]        bw;
    logic [5:0]        bh;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic [1:0]        rot;
  } lane_in_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] led_index;
  } lane_res_t;

endpackage

// ===== hdl/rotated_bitmap_blit_to_serpentine_matrix.sv =====
// Bitmap blit to a serpentine LED matrix. Each accepted transaction is one byte
// of a 1-bit-per-pixel bitmap; eight lanes map its pixels in parallel (rotate,
// clip, serpentine index from the bottom row) over two pipeline stages, and a
// merge buffer sends the surviving writes out in order, bit 7 first, one per
// cycle while result_stall is low, with last on the final write of the byte.
// The next byte is taken while the current one drains. The first write passes
// through the lane registers, the merge buffer's pending flags and the result
// register. Matrix size registers are written through cfg_write/cfg_index/
// cfg_data; the user must write them only while no byte is in flight, as the
// block itself does not enforce it.
module rotated_bitmap_blit_to_serpentine_matrix #(
  parameter int MAX_MATRIX_SIDE = rbs_pkg::DEF_MAX_MATRIX_SIDE,
  parameter int MAX_BITMAP_SIDE = rbs_pkg::DEF_MAX_BITMAP_SIDE
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [6:0]       cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  rbs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output rbs_pkg::result_t result
);
  import rbs_pkg::*;

  logic [6:0]  matrix_width;
  logic [6:0]  matrix_height;
  logic [6:0]  mw;
  logic [6:0]  mh;
  logic [5:0]  bw;
  logic [5:0]  bh;
  logic        s1_valid;
  logic [23:0] s1_color;
  logic        accept;
  logic        load;
  logic        free;
  lane_in_t    lane_in [NUM_LANES];
  lane_res_t   lane_res [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_width  <= MATRIX_SIDE_RESET;
      matrix_height <= MATRIX_SIDE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        CFG_MATRIX_WIDTH:  matrix_width  <= cfg_data;
        CFG_MATRIX_HEIGHT: matrix_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mw = (int'(matrix_width) > MAX_MATRIX_SIDE) ? 7'(MAX_MATRIX_SIDE) : matrix_width;
    mh = (int'(matrix_height) > MAX_MATRIX_SIDE) ? 7'(MAX_MATRIX_SIDE) : matrix_height;
    bw = (int'(item.bitmap_width) > MAX_BITMAP_SIDE) ? 6'(MAX_BITMAP_SIDE)
                                                     : item.bitmap_width;
    bh = (int'(item.bitmap_height) > MAX_BITMAP_SIDE) ? 6'(MAX_BITMAP_SIDE)
                                                      : item.bitmap_height;
    load       = s1_valid && free;
    item_stall = s1_valid && !free;
    accept     = item_valid && !item_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept || load) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_color <= item.pixel_color;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    always_comb begin
      lane_in[i].pix  = item.bitmap_byte[NUM_LANES-1-i];
      lane_in[i].bcol = item.byte_column;
      lane_in[i].row  = item.bitmap_row;
      lane_in[i].bw   = bw;
      lane_in[i].bh   = bh;
      lane_in[i].ox   = item.origin_x;
      lane_in[i].oy   = item.origin_y;
      lane_in[i].rot  = item.rotation[1:0];
    end

    rbs_lane #(
      .LANE(i)
    ) u_lane (
      .clk     (clk),
      .en      (accept),
      .lane_in (lane_in[i]),
      .mw      (mw),
      .mh      (mh),
      .res     (lane_res[i])
    );
  end

  rbs_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .lane_res     (lane_res),
    .color        (s1_color),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost before merge");

  a_held_until_load: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !load |=> s1_valid && $stable(s1_color))
    else $error("lane stage dropped without merge load");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("stall with empty lane stage");
`endif

endmodule

// ===== hdl/rbs_lane.sv =====
module rbs_lane #(
  parameter int LANE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  rbs_pkg::lane_in_t lane_in,
  input  logic [6:0]       mw,
  input  logic [6:0]       mh,
  output rbs_pkg::lane_res_t res
);
  import rbs_pkg::*;

  logic [4:0]        w;
  logic              flip_x;
  logic              flip_y;
  logic              swap;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic signed [7:0] oa;
  logic signed [7:0] ob;
  logic signed [7:0] da;
  logic signed [7:0] db;
  logic              hit_next;
  logic signed [9:0] px_next;
  logic signed [9:0] py_next;

  logic              hit;
  logic signed [9:0] px;
  logic signed [9:0] py;

  logic              in_x;
  logic              in_y;
  logic [6:0]        ry;
  logic [6:0]        col;
  logic [13:0]       prod;
  logic [13:0]       idx;

  // stage 1: flip, swap, offset and bitmap bounds check
  always_comb begin
    w      = {lane_in.bcol, 3'(LANE)};
    flip_x = lane_in.rot[1];
    flip_y = lane_in.rot[1] ^ lane_in.rot[0];
    swap   = lane_in.rot[0];
    dx = flip_x ? $signed({2'b00, lane_in.bw}) - 8'sd1 - $signed({3'b000, w})
                : $signed({3'b000, w});
    dy = flip_y ? $signed({2'b00, lane_in.bh}) - 8'sd1 - $signed({3'b000, lane_in.row})
                : $signed({3'b000, lane_in.row});
    oa = swap ? lane_in.oy : lane_in.ox;
    ob = swap ? lane_in.ox : lane_in.oy;
    da = swap ? dy : dx;
    db = swap ? dx : dy;
    px_next = {{2{oa[7]}}, oa} + {{2{da[7]}}, da};
    py_next = {{2{ob[7]}}, ob} + {{2{db[7]}}, db};
    hit_next = lane_in.pix && ({1'b0, w} < lane_in.bw)
               && ({1'b0, lane_in.row} < lane_in.bh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
      px  <= px_next;
      py  <= py_next;
    end
  end

  // stage 2: clip and serpentine index
  always_comb begin
    in_x = !px[9] && (px[8:0] < {2'b00, mw});
    in_y = !py[9] && (py[8:0] < {2'b00, mh});
    ry   = mh - 7'd1 - py[6:0];
    col  = ry[0] ? px[6:0] : (mw - 7'd1 - px[6:0]);
    prod = {7'b0, ry} * {7'b0, mw};
    idx  = prod + {7'b0, col};
    res.hit       = hit && in_x && in_y;
    res.led_index = idx[11:0];
  end

endmodule

// ===== hdl/rbs_merge.sv =====
module rbs_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rbs_pkg::lane_res_t lane_res [rbs_pkg::NUM_LANES],
  input  logic [23:0]        color,
  output logic               free,
  output logic               result_valid,
  input  logic               result_stall,
  output rbs_pkg::result_t   result
);
  import rbs_pkg::*;

  localparam int SelW = $clog2(NUM_LANES);

  logic [NUM_LANES-1:0] pend;
  logic [NUM_LANES-1:0] pend_next;
  logic [11:0]          idx_buf [NUM_LANES];
  logic [23:0]          color_buf;
  logic                 out_free;
  logic                 pick;
  logic [SelW-1:0]      sel;
  logic [NUM_LANES-1:0] pend_after;

  always_comb begin
    sel = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SelW'(i);
      end
    end
    out_free   = !result_valid || !result_stall;
    pick       = out_free && (pend != '0);
    pend_after = pick ? (pend & ~(NUM_LANES'(1) << sel)) : pend;
    free       = (pend_after == '0);
    for (int i = 0; i < NUM_LANES; i++) begin
      pend_next[i] = lane_res[i].hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= '0;
      result_valid <= 1'b0;
    end else begin
      pend <= load ? pend_next : pend_after;
      if (out_free) begin
        result_valid <= pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        idx_buf[i] <= lane_res[i].led_index;
      end
      color_buf <= color;
    end
    if (pick) begin
      result.led_index   <= idx_buf[sel];
      result.write_color <= color_buf;
      result.last        <= (pend_after == '0);
    end
  end

`ifndef SYNTH
  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    pend != '0 |=> result_valid)
    else $error("pending write not presented");

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> pend != '0)
    else $error("non-final write with nothing pending");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> pend_after == '0)
    else $error("buffer reloaded with writes pending");
`endif

endmodule

// ===== tb/sv/tb_rotated_bitmap_blit_to_serpentine_matrix.sv =====
module tb_rotated_bitmap_blit_to_serpentine_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  import rbs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int BYTES_PER_PHASE = 27;

  typedef struct {
    bit    drain_first;
    item_t payload;
  } queued_byte_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [0:0] cfg_index;
  logic [6:0] cfg_data;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       result_valid;
  logic       result_stall;
  result_t    result;

  queued_byte_t bytes_to_send[$];
  result_t      led_writes_due[$];
  logic [6:0]   matrix_w_mirror;
  logic [6:0]   matrix_h_mirror;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           bytes_queued;
  int           bytes_accepted;
  int           error_count;
  int           cycle_count;
  logic         byte_taken;

  rotated_bitmap_blit_to_serpentine_matrix DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected led writes for one accepted bitmap byte
  function automatic void blit_byte(item_t it);
    int         bw, bh, mw, mh, row, col, dx, dy, px, py, ry, idx, n;
    logic [1:0] quarter;
    result_t    wr;
    bw = (it.bitmap_width > DEF_MAX_BITMAP_SIDE) ? DEF_MAX_BITMAP_SIDE : it.bitmap_width;
    bh = (it.bitmap_height > DEF_MAX_BITMAP_SIDE) ? DEF_MAX_BITMAP_SIDE : it.bitmap_height;
    mw = (matrix_w_mirror > DEF_MAX_MATRIX_SIDE) ? DEF_MAX_MATRIX_SIDE : matrix_w_mirror;
    mh = (matrix_h_mirror > DEF_MAX_MATRIX_SIDE) ? DEF_MAX_MATRIX_SIDE : matrix_h_mirror;
    row = it.bitmap_row;
    quarter = it.rotation[1:0];
    n = 0;
    if (row >= bh) begin
      return;
    end
    for (int b = 7; b >= 0; b--) begin
      col = it.byte_column * 8 + (7 - b);
      if (col >= bw || !it.bitmap_byte[b]) begin
        continue;
      end
      dx = quarter[1] ? bw - 1 - col : col;
      dy = (quarter == 2'd1 || quarter == 2'd2) ? bh - 1 - row : row;
      if (quarter[0]) begin
        px = int'(it.origin_y) + dy;
        py = int'(it.origin_x) + dx;
      end else begin
        px = int'(it.origin_x) + dx;
        py = int'(it.origin_y) + dy;
      end
      if (px < 0 || py < 0 || px >= mw || py >= mh) begin
        continue;
      end
      ry = mh - 1 - py;
      idx = ry[0] ? ry * mw + px : ry * mw + (mw - 1 - px);
      wr.led_index = idx[11:0];
      wr.write_color = it.pixel_color;
      wr.last = 1'b0;
      led_writes_due.push_back(wr);
      n++;
    end
    if (n > 0) begin
      led_writes_due[led_writes_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic item_t make_byte(logic [7:0] pixels, int bcol, int row, int bw, int bh,
                                      int ox, int oy, int rot, logic [23:0] color);
    item_t it;
    it.bitmap_byte = pixels;
    it.byte_column = 2'(bcol);
    it.bitmap_row = 5'(row);
    it.bitmap_width = 6'(bw);
    it.bitmap_height = 6'(bh);
    it.origin_x = 8'(ox);
    it.origin_y = 8'(oy);
    it.rotation = 8'(rot);
    it.pixel_color = color;
    return it;
  endfunction

  // mostly well-formed bytes that land near the matrix, some pure noise
  function automatic item_t random_byte();
    item_t it;
    int    span, bw, bh;
    span = (matrix_w_mirror > matrix_h_mirror) ? matrix_w_mirror : matrix_h_mirror;
    if (span > DEF_MAX_MATRIX_SIDE) begin
      span = DEF_MAX_MATRIX_SIDE;
    end
    it.bitmap_byte = 8'($urandom);
    it.pixel_color = 24'($urandom);
    it.rotation = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      it.byte_column = 2'($urandom);
      it.bitmap_row = 5'($urandom);
      it.bitmap_width = 6'($urandom);
      it.bitmap_height = 6'($urandom);
      it.origin_x = 8'($urandom);
      it.origin_y = 8'($urandom);
    end else begin
      bw = $urandom_range(32, 1);
      bh = $urandom_range(32, 1);
      it.bitmap_width = 6'(bw);
      it.bitmap_height = 6'(bh);
      it.bitmap_row = 5'($urandom_range(bh - 1));
      it.byte_column = 2'($urandom_range((bw - 1) / 8));
      it.origin_x = 8'(int'($urandom_range(span)) - int'($urandom_range(12)));
      it.origin_y = 8'(int'($urandom_range(span)) - int'($urandom_range(12)));
    end
    return it;
  endfunction

  task automatic queue_byte(item_t it, bit drain_first);
    queued_byte_t q;
    q.drain_first = drain_first;
    q.payload = it;
    bytes_to_send.push_back(q);
    bytes_queued++;
  endtask

  task automatic set_matrix(logic [6:0] w, logic [6:0] h);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MATRIX_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= CFG_MATRIX_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    matrix_w_mirror = w;
    matrix_h_mirror = h;
  endtask

  task automatic wait_quiet();
    while (bytes_accepted != bytes_queued || led_writes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive
    queued_byte_t nxt;
    if (!rst) begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!item_valid || byte_taken) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(bytes_to_send[0].drain_first && led_writes_due.size() != 0)) begin
          nxt = bytes_to_send.pop_front();
          item <= nxt.payload;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t due;
    cycle_count++;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (led_writes_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected led write, index %0d color %06h last %0b", $time,
                   result.led_index, result.write_color, result.last);
        end else begin
          due = led_writes_due.pop_front();
          if (result.led_index !== due.led_index) begin
            error_count++;
            $display("%0t: led_index expected %0d got %0d", $time, due.led_index,
                     result.led_index);
          end
          if (result.write_color !== due.write_color) begin
            error_count++;
            $display("%0t: write_color expected %06h got %06h", $time, due.write_color,
                     result.write_color);
          end
          if (result.last !== due.last) begin
            error_count++;
            $display("%0t: last expected %0b got %0b", $time, due.last, result.last);
          end
        end
      end
      if (item_valid && !item_stall) begin
        blit_byte(item);
        bytes_accepted++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [6:0] phase_w[RANDOM_PHASES];
    logic [6:0] phase_h[RANDOM_PHASES];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_MATRIX_WIDTH;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    matrix_w_mirror = MATRIX_SIDE_RESET;
    matrix_h_mirror = MATRIX_SIDE_RESET;
    send_idle_pct = 34;
    recv_idle_pct = 68;
    bytes_queued = 0;
    bytes_accepted = 0;
    error_count = 0;
    cycle_count = 0;
    phase_w = '{7'd8, 7'd64, 7'd1, 7'd127, 7'd0, 7'd33, 7'd12, 7'd16};
    phase_h = '{7'd8, 7'd64, 7'd1, 7'd100, 7'd20, 7'd7, 7'd64, 7'd16};
    phase_w[7] = 7'($urandom_range(64, 1));
    phase_h[7] = 7'($urandom_range(64, 1));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed bytes on the reset matrix size
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 0, 0, 0, 24'hFFFFFF), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 0, 0, 1, 24'h123456), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 0, 0, 2, 24'h654321), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 0, 0, 3, 24'h00FF00), 0);
    queue_byte(make_byte(8'h80, 3, 31, 32, 32, -24, -31, 0, 24'h000000), 0);
    queue_byte(make_byte(8'h01, 3, 31, 32, 32, -10, -20, -1, 24'hFFFFFF), 0);
    queue_byte(make_byte(8'hA5, 1, 5, 12, 10, 2, 3, -128, 24'hAAAAAA), 0);
    queue_byte(make_byte(8'hFF, 0, 9, 8, 8, 0, 0, 0, 24'h111111), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 0, 8, 0, 0, 0, 24'h222222), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 0, 0, 0, 0, 24'h333333), 0);
    queue_byte(make_byte(8'hFF, 2, 3, 63, 63, -16, 2, 0, 24'h444444), 0);
    queue_byte(make_byte(8'h00, 0, 0, 8, 8, 0, 0, 0, 24'h555555), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, -128, -128, 0, 24'h666666), 0);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 127, 127, 2, 24'h777777), 0);
    queue_byte(make_byte(8'hFF, 1, 15, 16, 16, 8, 0, 127, 24'h555555), 0);
    queue_byte(make_byte(8'h3C, 0, 0, 8, 1, 10, 15, 0, 24'h888888), 0);
    queue_byte(make_byte(8'hFF, 0, 7, 8, 8, -4, 12, 1, 24'h999999), 0);
    queue_byte(make_byte(8'hC3, 3, 0, 32, 1, -20, 5, 2, 24'hABCDEF), 1);
    queue_byte(make_byte(8'hFF, 0, 0, 8, 8, 4, 4, 126, 24'hFEDCBA), 0);
    queue_byte(make_byte(8'h7E, 1, 2, 16, 4, 0, 0, 5, 24'h0F0F0F), 0);
    wait_quiet();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 68;
      end else if (ph < 6) begin
        send_idle_pct = 68;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_matrix(phase_w[ph], phase_h[ph]);
      for (int k = 0; k < BYTES_PER_PHASE; k++) begin
        queue_byte(random_byte(), k == BYTES_PER_PHASE / 2);
      end
      wait_quiet();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rbs_pkg.sv
hdl/rbs_lane.sv
hdl/rbs_merge.sv
hdl/rotated_bitmap_blit_to_serpentine_matrix.sv
tb/sv/tb_rotated_bitmap_blit_to_serpentine_matrix.sv
